>>> design/rasc_pkg.sv
// Package for the rational add/subtract/compare block: operation codes and widths.
// No dependencies.
`default_nettype none
package rasc_pkg;
   localparam int NumWidth = 33;
   localparam int DenWidth = 31;
   localparam int MagWidth = 32;
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_CMP = 2'd2;
endpackage
`default_nettype wire

>>> design/rasc_gcd.sv
// Iterative binary GCD unit, one shift/subtract step per cycle.
// Depends on rasc_pkg.
`default_nettype none
module rasc_gcd
   import rasc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [MagWidth-1:0] opa,
   input  wire logic [MagWidth-1:0] opb,
   output logic                     done,
   output logic [MagWidth-1:0]      result
);
   typedef enum logic [1:0] {S_IDLE, S_STRIP, S_RUN, S_DONE} state_type;
   state_type           state_ff;
   logic [MagWidth-1:0] a_ff, b_ff;
   logic [5:0]          k_ff;
   logic [MagWidth-1:0] diff;

   assign diff   = (a_ff > b_ff) ? a_ff - b_ff : b_ff - a_ff;
   assign done   = (state_ff == S_DONE);
   assign result = a_ff << k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  a_ff <= opa;
                  b_ff <= opb;
                  k_ff <= '0;
                  state_ff <= S_STRIP;
               end
            end
            S_STRIP: begin
               if (!a_ff[0] && !b_ff[0]) begin
                  a_ff <= a_ff >> 1;
                  b_ff <= b_ff >> 1;
                  k_ff <= k_ff + 6'd1;
               end else begin
                  state_ff <= S_RUN;
               end
            end
            S_RUN: begin
               if (b_ff == '0) begin
                  state_ff <= S_DONE;
               end else if (!a_ff[0]) begin
                  a_ff <= a_ff >> 1;
               end else if (!b_ff[0]) begin
                  b_ff <= b_ff >> 1;
               end else begin
                  a_ff <= (a_ff < b_ff) ? a_ff : b_ff;
                  b_ff <= diff;
               end
            end
            S_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

>>> design/rasc_div.sv
// Restoring divider, one quotient bit per cycle, exact 32-bit unsigned quotient.
// Depends on rasc_pkg.
`default_nettype none
module rasc_div
   import rasc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [MagWidth-1:0] dividend,
   input  wire logic [MagWidth-1:0] divisor,
   output logic                     done,
   output logic [MagWidth-1:0]      quotient
);
   logic                busy_ff, done_ff;
   logic [5:0]          cnt_ff;
   logic [MagWidth-1:0] q_ff, d_ff;
   logic [MagWidth:0]   r_ff, trial;

   assign trial    = {r_ff[MagWidth-1:0], q_ff[MagWidth-1]} - {1'b0, d_ff};
   assign done     = done_ff;
   assign quotient = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            q_ff    <= dividend;
            d_ff    <= divisor;
            r_ff    <= '0;
            cnt_ff  <= 6'(MagWidth);
         end else if (busy_ff) begin
            if (!trial[MagWidth]) begin
               r_ff <= trial;
               q_ff <= {q_ff[MagWidth-2:0], 1'b1};
            end else begin
               r_ff <= {r_ff[MagWidth-1:0], q_ff[MagWidth-1]};
               q_ff <= {q_ff[MagWidth-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
endmodule
`default_nettype wire

>>> design/rational_add_sub_compare.sv
// Top level of the rational add/subtract/compare block: sequencer and stream ports.
// Depends on rasc_pkg, rasc_gcd and rasc_div.
// The three products share one 16 by 16 multiplier in states S_MUL1, S_MUL2 and
// S_MUL3. The binary GCD unit takes one shift or subtract step per cycle and first
// strips each common factor of two. The two divisions run one after the other on
// one shared divider. Compare goes from S_SUM to S_OUT, and a zero result numerator
// from S_GCD. A zero denominator or the unused operation goes from S_IDLE to S_OUT.
// req_tready is high only while the block is idle and the result slot is empty.
`default_nettype none
module rational_add_sub_compare
   import rasc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,  // op[1:0] num_a[17:2] den_a[33:18] num_b[49:34] den_b[65:50]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata   // res_num[32:0] res_den[63:33] is_equal[64] div_zero[65]
);
   typedef enum logic [3:0] {
      S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_SUM, S_GCD, S_WGCD, S_DIVN, S_WDIVN, S_DIVD,
      S_WDIVD, S_OUT
   } state_type;
   state_type           state_ff;
   logic [1:0]          op_ff;
   logic signed [15:0]  na_ff, da_ff, nb_ff, db_ff;
   logic signed [31:0]  p1_ff, p2_ff, cd_ff;
   logic signed [33:0]  n_ff;
   logic                neg_ff;
   logic [MagWidth-1:0] an_ff, ad_ff, g_ff, qn_ff;
   logic                rvalid_ff;
   logic [NumWidth-1:0] rnum_ff;
   logic [DenWidth-1:0] rden_ff;
   logic                req_ff, dz_ff;
   logic signed [15:0]  mx, my;
   logic signed [31:0]  prod;
   logic                gstart, gdone, dstart, ddone;
   logic [MagWidth-1:0] gres, dq, dvd;
   logic signed [33:0]  nsum;
   logic [33:0]         nabs;
   logic [31:0]         cabs;

   assign req_tready = (state_ff == S_IDLE) && !rvalid_ff;
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {6'd0, dz_ff, req_ff, rden_ff, rnum_ff};

   assign mx   = (state_ff == S_MUL1) ? db_ff : da_ff;
   assign my   = (state_ff == S_MUL1) ? na_ff : ((state_ff == S_MUL2) ? nb_ff : db_ff);
   assign prod = mx * my;
   assign nsum = (op_ff == OP_ADD) ? 34'(p1_ff) + 34'(p2_ff) : 34'(p1_ff) - 34'(p2_ff);
   assign nabs = n_ff[33] ? 34'(-n_ff) : 34'(n_ff);
   assign cabs = cd_ff[31] ? 32'(-cd_ff) : 32'(cd_ff);
   assign gstart = (state_ff == S_GCD) && (n_ff != '0);
   assign dstart = (state_ff == S_DIVN) || (state_ff == S_DIVD);
   assign dvd    = (state_ff == S_DIVN) ? an_ff : ad_ff;

   rasc_gcd u_gcd (
      .clock(clock), .reset(reset), .start(gstart), .opa(nabs[31:0]), .opb(cabs),
      .done(gdone), .result(gres)
   );
   rasc_div u_div (
      .clock(clock), .reset(reset), .start(dstart), .dividend(dvd), .divisor(g_ff),
      .done(ddone), .quotient(dq)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rvalid_ff <= 1'b0;
      end else begin
         if (rvalid_ff && rsp_tready) begin
            rvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  op_ff <= req_tdata[1:0];
                  na_ff <= req_tdata[17:2];
                  da_ff <= req_tdata[33:18];
                  nb_ff <= req_tdata[49:34];
                  db_ff <= req_tdata[65:50];
                  rnum_ff <= '0;
                  rden_ff <= '0;
                  req_ff  <= 1'b0;
                  dz_ff   <= (req_tdata[33:18] == '0 || req_tdata[65:50] == '0);
                  if (req_tdata[33:18] == '0 || req_tdata[65:50] == '0) begin
                     state_ff <= S_OUT;
                  end else if (req_tdata[1:0] == 2'd3) begin
                     state_ff <= S_OUT;
                  end else begin
                     state_ff <= S_MUL1;
                  end
               end
            end
            S_MUL1: begin
               p1_ff    <= prod;
               state_ff <= S_MUL2;
            end
            S_MUL2: begin
               p2_ff    <= prod;
               state_ff <= S_MUL3;
            end
            S_MUL3: begin
               if (op_ff != OP_CMP && da_ff == db_ff) begin
                  p1_ff <= 32'(na_ff);
                  p2_ff <= 32'(nb_ff);
                  cd_ff <= 32'(da_ff);
               end else begin
                  cd_ff <= prod;
               end
               state_ff <= S_SUM;
            end
            S_SUM: begin
               if (op_ff == OP_CMP) begin
                  req_ff   <= (p1_ff == p2_ff);
                  state_ff <= S_OUT;
               end else begin
                  n_ff     <= nsum;
                  state_ff <= S_GCD;
               end
            end
            S_GCD: begin
               neg_ff <= n_ff[33] ^ cd_ff[31];
               an_ff  <= nabs[31:0];
               ad_ff  <= cabs;
               if (n_ff == '0) begin
                  rden_ff  <= 31'd1;
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_WGCD;
               end
            end
            S_WGCD: begin
               if (gdone) begin
                  g_ff     <= gres;
                  state_ff <= S_DIVN;
               end
            end
            S_DIVN: state_ff <= S_WDIVN;
            S_WDIVN: begin
               if (ddone) begin
                  qn_ff    <= dq;
                  state_ff <= S_DIVD;
               end
            end
            S_DIVD: state_ff <= S_WDIVD;
            S_WDIVD: begin
               if (ddone) begin
                  rnum_ff  <= neg_ff ? 33'(-{1'b0, qn_ff}) : {1'b0, qn_ff};
                  rden_ff  <= dq[DenWidth-1:0];
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               rvalid_ff <= 1'b1;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

>>> test/testbench.sv
// Testbench for rational_add_sub_compare: random and directed fraction transactions.
// Depends on rasc_pkg and the rational_add_sub_compare RTL; prediction is computed locally.
`timescale 1ns / 1ps
module testbench
   import rasc_pkg::*;
();

   typedef struct packed {
      logic signed [15:0] den_b;
      logic signed [15:0] num_b;
      logic signed [15:0] den_a;
      logic signed [15:0] num_a;
      logic [1:0]         op;
   } frac_item_type;

   typedef struct packed {
      logic                       div_zero;
      logic                       is_equal;
      logic [DenWidth-1:0]        res_den;
      logic signed [NumWidth-1:0] res_num;
   } frac_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;

   frac_item_type   pending_items[$];
   frac_result_type expected_fracs[$];
   int              error_count;
   bit              stimulus_done;
   bit              req_taken;
   int              burst_left;
   int              gap_left;
   int              hold_left;
   int              stall_cycle;

   rational_add_sub_compare i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
      longint unsigned t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic frac_result_type reduced_result(frac_item_type it);
      frac_result_type r;
      longint          na, da, nb, db, cd, sa, sb, n;
      longint unsigned an, ad, g;
      bit              neg;
      r = '0;
      na = it.num_a;
      da = it.den_a;
      nb = it.num_b;
      db = it.den_b;
      if (da == 0 || db == 0) begin
         r.div_zero = 1'b1;
      end else if (it.op == OP_ADD || it.op == OP_SUB) begin
         if (da == db) begin
            cd = da;
            sa = na;
            sb = nb;
         end else begin
            cd = da * db;
            sa = db * na;
            sb = da * nb;
         end
         n = (it.op == OP_ADD) ? sa + sb : sa - sb;
         neg = (n < 0) != (cd < 0);
         an = (n < 0) ? -n : n;
         ad = (cd < 0) ? -cd : cd;
         if (an == 0) begin
            r.res_num = '0;
            r.res_den = DenWidth'(1);
         end else begin
            g = gcd_of(an, ad);
            an = an / g;
            ad = ad / g;
            r.res_num = NumWidth'(neg ? -longint'(an) : longint'(an));
            r.res_den = DenWidth'(ad);
         end
      end else if (it.op == OP_CMP) begin
         r.is_equal = (na * db == nb * da);
      end
      return r;
   endfunction

   function automatic logic [15:0] edge_value();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'h0001;
         4: return 16'hffff;
         5: return 16'($urandom_range(0, 15)) - 16'd8;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic add_item(logic [1:0] op, logic [15:0] na, logic [15:0] da,
                           logic [15:0] nb, logic [15:0] db);
      frac_item_type it;
      it.op = op;
      it.num_a = na;
      it.den_a = da;
      it.num_b = nb;
      it.den_b = db;
      pending_items.push_back(it);
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      int i;
      int k;
      logic [15:0] na, da;
      reset = 1'b1;
      error_count = 0;
      stimulus_done = 1'b0;
      add_item(OP_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
      add_item(OP_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd2);
      add_item(OP_ADD, 16'sd3, 16'sd4, 16'sd1, 16'sd4);
      add_item(OP_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      add_item(OP_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
      add_item(OP_ADD, 16'h8000, 16'h7fff, 16'h8000, 16'h7ffe);
      add_item(OP_SUB, 16'h7fff, 16'h0001, 16'h8000, 16'h0001);
      add_item(OP_ADD, 16'sd5, -16'sd3, 16'sd0, 16'sd7);
      add_item(OP_SUB, 16'sd0, -16'sd5, 16'sd0, 16'sd9);
      add_item(OP_ADD, -16'sd6, -16'sd4, 16'sd0, 16'sd1);
      add_item(OP_CMP, 16'sd1, 16'sd2, 16'sd2, 16'sd4);
      add_item(OP_CMP, 16'sd1, 16'sd2, -16'sd1, -16'sd2);
      add_item(OP_CMP, 16'sd0, 16'sd3, 16'sd0, -16'sd7);
      add_item(OP_CMP, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
      add_item(OP_CMP, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
      add_item(OP_ADD, 16'sd1, 16'sd0, 16'sd1, 16'sd1);
      add_item(OP_SUB, 16'sd1, 16'sd1, 16'sd1, 16'sd0);
      add_item(OP_CMP, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      add_item(2'd3, 16'sd1, 16'sd2, 16'sd3, 16'sd4);
      add_item(2'd3, 16'sd1, 16'sd0, 16'sd3, 16'sd4);
      add_item(OP_ADD, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
      add_item(OP_SUB, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
      for (i = 0; i < 1850; i++) begin
         k = $urandom_range(0, 9);
         na = ($urandom_range(0, 1)) ? 16'($urandom) : edge_value();
         da = ($urandom_range(0, 1)) ? 16'($urandom) : edge_value();
         if (k < 2)
            add_item(2'($urandom_range(0, 3)), na, da, 16'($urandom), 16'($urandom));
         else if (k < 4)
            add_item(2'($urandom_range(0, 3)), na, da, na * 16'($urandom_range(1, 3)),
                     da * 16'($urandom_range(1, 3)));
         else if (k < 5)
            add_item(2'($urandom_range(0, 3)), na, da, edge_value(), da);
         else
            add_item(2'($urandom_range(0, 3)), na, da, edge_value(), edge_value());
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      wait (pending_items.size() == 0 && !req_tvalid);
      stimulus_done = 1'b1;
   end

   // sender: bursts with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         burst_left = $urandom_range(1, 20);
         gap_left = 0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left > 0 || pending_items.size() == 0) begin
            if (gap_left > 0)
               gap_left--;
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata <= {6'd0, pending_items.pop_front()};
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 20);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
            end
         end
      end
   end

   // receiver: own stall pattern, with long hold-offs now and then
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
         stall_cycle = 0;
      end else begin
         stall_cycle++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_cycle % 7000 == 500) begin
            hold_left = 2000;
            rsp_tready <= 1'b0;
         end else if ((stall_cycle / 3000) % 2 == 1) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 3) != 0) && (stall_cycle % 11 < 8);
         end
      end
   end

   always @(posedge clock) begin
      frac_result_type act, exp_r;
      req_taken = !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready)
         expected_fracs.push_back(reduced_result(frac_item_type'(req_tdata[65:0])));
      if (!reset && rsp_tvalid && rsp_tready) begin
         act = frac_result_type'(rsp_tdata[65:0]);
         if (expected_fracs.size() == 0) begin
            $error("unexpected transaction: %h", rsp_tdata);
            error_count++;
         end else begin
            exp_r = expected_fracs.pop_front();
            if (act.res_num !== exp_r.res_num) begin
               $error("res_num expected %0d actual %0d", exp_r.res_num, act.res_num);
               error_count++;
            end
            if (act.res_den !== exp_r.res_den) begin
               $error("res_den expected %0d actual %0d", exp_r.res_den, act.res_den);
               error_count++;
            end
            if (act.is_equal !== exp_r.is_equal) begin
               $error("is_equal expected %0d actual %0d", exp_r.is_equal, act.is_equal);
               error_count++;
            end
            if (act.div_zero !== exp_r.div_zero) begin
               $error("div_zero expected %0d actual %0d", exp_r.div_zero, act.div_zero);
               error_count++;
            end
         end
      end
   end

   initial begin
      wait (stimulus_done);
      wait (expected_fracs.size() == 0);
      repeat (300) @(posedge clock);
      if (expected_fracs.size() != 0) begin
         $error("%0d transactions outstanding", expected_fracs.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
